// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the merge sort engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/mse_pkg.sv
// Shared types and constants of the merge sort engine.
package mse_pkg;

    localparam int DATA_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the incoming word in the primary store
        logic clear;       // start a new set before the load is stored
        logic sort_begin;  // the set is closed, prepare the first merge pass
        logic fetch;       // read out the next sorted word
        logic sorted;      // the current set has been sorted
        logic run_init;    // set up the pointers of the next pair of runs
        logic merge_step;  // move one word from source to destination store
        logic next_run;    // the pair of runs is done, move to the next pair
        logic pass_end;    // the pass is done, double the run width and swap
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic run_last;    // this merge step writes the last word of the pair
        logic pass_last;   // the current pair of runs ends the pass
        logic sort_done;   // the run width covers the whole set
    } t_dp_stat;

endpackage

// File: hw/rtl/mse_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_qa;
    logic [WIDTH-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_qa <= r_mem[i_raddr_a];
        r_qb <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_qa;
    assign o_rdata_b = r_qb;

endmodule

// File: hw/rtl/mse_ctrl.sv
// Controller state machine of the merge sort engine.
module mse_ctrl
    import mse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_opcode,
    input  logic     i_last_load,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN_INIT,
        S_MERGE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_sorted, n_sorted;
    t_dp_cmd cmd;

    always_comb begin
        n_state  = r_state;
        n_sorted = r_sorted;
        cmd      = '0;
        cmd.sorted = r_sorted;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!i_opcode) begin
                        cmd.load  = 1'b1;
                        cmd.clear = r_sorted;
                        n_sorted  = 1'b0;
                        if (i_last_load) begin
                            cmd.sort_begin = 1'b1;
                            n_state        = S_RUN_INIT;
                        end
                    end else begin
                        cmd.fetch = 1'b1;
                    end
                end
            end
            S_RUN_INIT: begin
                if (i_stat.sort_done) begin
                    n_sorted = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    cmd.run_init = 1'b1;
                    n_state      = S_MERGE;
                end
            end
            S_MERGE: begin
                cmd.merge_step = 1'b1;
                if (i_stat.run_last) begin
                    n_state = S_RUN_INIT;
                    if (i_stat.pass_last) begin
                        cmd.pass_end = 1'b1;
                    end else begin
                        cmd.next_run = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_sorted <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_sorted <= n_sorted;
        end
    end

    assign o_cmd = cmd;
    assign busy  = r_busy;

endmodule

// File: hw/rtl/mse_dp.sv
// Datapath of the merge sort engine: stores, merge pointers and fetch stage.
module mse_dp
    import mse_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_element_value,
    output t_dp_stat                 o_stat,
    output logic                     o_result_valid,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_element,
    output logic                     o_no_data,
    output logic                     o_overflowed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam int XW = CW + 2;

    // Control state.
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rp;
    logic          r_ovf;
    logic          r_in_scratch;
    logic          r_res_valid;

    // Merge pointers and fetch result.
    logic [WW-1:0] r_w;
    logic [CW-1:0] r_lo, r_i, r_j, r_mid, r_hi, r_k;
    logic          r_res_hit, r_res_final, r_res_ovf, r_res_sel;

    logic [CW-1:0]     cnt_base;
    logic              full;
    logic [XW-1:0]     sum_mid, sum_hi, n_x;
    logic [CW-1:0]     mid_calc, hi_calc;
    logic              take_left;
    logic [CW-1:0]     n_i, n_j;
    logic [DATA_W-1:0] src_a, src_b, merge_data;
    logic [DATA_W-1:0] p_qa, p_qb, s_qa, s_qb;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic              p_we, s_we;
    logic [AW-1:0]     p_waddr;
    logic [DATA_W-1:0] p_wdata;
    logic              hit;

    // Loads: a new set restarts at entry zero.
    assign cnt_base = i_cmd.clear ? '0 : r_count;
    assign full     = (cnt_base == CW'(DEPTH));

    // Bounds of the next pair of runs, clipped to the set size.
    assign n_x      = XW'(r_count);
    assign sum_mid  = XW'(r_lo) + XW'(r_w);
    assign sum_hi   = XW'(r_lo) + (XW'(r_w) << 1);
    assign mid_calc = (sum_mid < n_x) ? sum_mid[CW-1:0] : r_count;
    assign hi_calc  = (sum_hi < n_x) ? sum_hi[CW-1:0] : r_count;

    // Merge decision; equal keys take the left run first.
    assign src_a      = r_in_scratch ? s_qa : p_qa;
    assign src_b      = r_in_scratch ? s_qb : p_qb;
    assign take_left  = (r_i < r_mid) &&
                        (!(r_j < r_hi) || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_left ? src_a : src_b;
    assign n_i        = r_i + {{(CW-1){1'b0}}, take_left};
    assign n_j        = r_j + {{(CW-1){1'b0}}, !take_left};

    // The read ports follow the pointers' next values, so the registered
    // data always belongs to the current pointers.
    always_comb begin
        if (i_cmd.run_init) begin
            raddr_a = r_lo[AW-1:0];
            raddr_b = mid_calc[AW-1:0];
        end else if (i_cmd.merge_step) begin
            raddr_a = n_i[AW-1:0];
            raddr_b = n_j[AW-1:0];
        end else begin
            raddr_a = r_rp[AW-1:0];
            raddr_b = r_rp[AW-1:0];
        end
    end

    assign p_we    = (i_cmd.load && !full) || (i_cmd.merge_step && r_in_scratch);
    assign p_waddr = i_cmd.load ? cnt_base[AW-1:0] : r_k[AW-1:0];
    assign p_wdata = i_cmd.load ? i_element_value : merge_data;
    assign s_we    = i_cmd.merge_step && !r_in_scratch;

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_primary (
        .i_clk     (i_clk),
        .i_we      (p_we),
        .i_waddr   (p_waddr),
        .i_wdata   (p_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (p_qa),
        .o_rdata_b (p_qb)
    );

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_scratch (
        .i_clk     (i_clk),
        .i_we      (s_we),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (merge_data),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (s_qa),
        .o_rdata_b (s_qb)
    );

    assign hit = i_cmd.sorted && (r_rp < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_rp         <= '0;
            r_ovf        <= 1'b0;
            r_in_scratch <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.fetch;
            if (i_cmd.load) begin
                if (i_cmd.clear) begin
                    r_rp         <= '0;
                    r_ovf        <= 1'b0;
                    r_in_scratch <= 1'b0;
                end
                if (full) begin
                    r_count <= cnt_base;
                    r_ovf   <= 1'b1;
                end else begin
                    r_count <= cnt_base + CW'(1);
                end
                if (i_cmd.sort_begin) begin
                    r_in_scratch <= 1'b0;
                end
            end
            if (i_cmd.pass_end) begin
                r_in_scratch <= !r_in_scratch;
            end
            if (i_cmd.fetch && hit) begin
                r_rp <= r_rp + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_begin) begin
            r_w  <= WW'(1);
            r_lo <= '0;
        end
        if (i_cmd.run_init) begin
            r_i   <= r_lo;
            r_j   <= mid_calc;
            r_k   <= r_lo;
            r_mid <= mid_calc;
            r_hi  <= hi_calc;
        end
        if (i_cmd.merge_step) begin
            r_i <= n_i;
            r_j <= n_j;
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.next_run) begin
            r_lo <= r_hi;
        end
        if (i_cmd.pass_end) begin
            r_lo <= '0;
            r_w  <= r_w << 1;
        end
        if (i_cmd.fetch) begin
            r_res_hit   <= hit;
            r_res_final <= hit && ((r_rp + CW'(1)) == r_count);
            r_res_ovf   <= r_ovf;
            r_res_sel   <= r_in_scratch;
        end
    end

    assign o_stat.run_last  = ((r_k + CW'(1)) == r_hi);
    assign o_stat.pass_last = (r_hi == r_count);
    assign o_stat.sort_done = (r_w >= WW'(r_count));

    assign o_result_valid  = r_res_valid;
    assign o_sorted_value  = r_res_hit ? (r_res_sel ? s_qa : p_qa) : '0;
    assign o_final_element = r_res_final;
    assign o_no_data       = !r_res_hit;
    assign o_overflowed    = r_res_ovf;

endmodule

// File: hw/rtl/merge_sort_engine.sv
// Merge sort engine: loads a set of signed words, sorts them stably, reads them back.
// A load gives no result; loads and fetches go one per cycle while the engine is not busy.
// A fetch gives its result word in the cycle after acceptance; the receiver cannot stall.
// After the last load the engine stays busy through the merge passes: a setup step for
// each pair of runs, a merge step for each word moved, and a final check that ends the sort.
// Synchronous active-low reset clears control state only; the stores need no clearing pass.
`include "assert_macros.svh"

module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_element_value,
    input  logic                     i_last_load,
    output logic                     o_result_valid,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_element,
    output logic                     o_no_data,
    output logic                     o_overflowed
);

    // The controller decides what happens in each cycle: it takes a word
    // when idle, and after the closing load it walks the bottom-up merge
    // passes, with a setup step for each pair of runs and a merge step for each word moved.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    mse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_opcode    (i_opcode),
        .i_last_load (i_last_load),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    // The datapath holds the two stores, which swap roles every pass, the
    // merge pointers and the fetch stage that presents each result word for
    // a single cycle.
    mse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_element_value (i_element_value),
        .o_stat          (stat),
        .o_result_valid  (o_result_valid),
        .o_sorted_value  (o_sorted_value),
        .o_final_element (o_final_element),
        .o_no_data       (o_no_data),
        .o_overflowed    (o_overflowed)
    );

    // Every accepted fetch gives exactly one result word in the next cycle.
    `ASSERT_NEXT(a_fetch_result, i_clk, i_rst_n, start && !busy && i_opcode, o_result_valid)
    // The closing load always hands over to the sorter.
    `ASSERT_NEXT(a_sort_busy, i_clk, i_rst_n, start && !busy && !i_opcode && i_last_load, busy)
    // A fetch that found nothing returns zero and is never the final word.
    `ASSERT_IMPLIES(a_no_data_zero, i_clk, i_rst_n, o_result_valid && o_no_data,
        (o_sorted_value == '0) && !o_final_element)
    // The datapath is never asked to do two kinds of work at once.
    `ASSERT_ALWAYS(a_cmd_excl, i_clk, i_rst_n,
        $onehot0({cmd.load, cmd.fetch, cmd.run_init, cmd.merge_step}))

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the merge sort engine: directed sets, a full set and random sets.
`timescale 1ns / 1ps

module tb_top;
    import mse_pkg::*;

    // The engine is built at its default capacity so that the full-set case is the real one.
    localparam int DEPTH = 1024;

    // Operation codes carried on i_opcode.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Roughly how many words the random part sends before it stops.
    localparam int RANDOM_WORDS = 250;

    // How many words of the full set are read back before a fresh set replaces it.
    localparam int FULL_READS = 400;

    // Cycles without any accepted word before the run is declared hung. The longest quiet
    // stretch is the sort of a full set, and this limit leaves a wide margin over it.
    localparam int HANG_LIMIT = 60000;

    // One expected result word, as the engine should present it.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     final_flag;
        logic                     empty;
        logic                     ovf;
    } t_sorted_word;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_opcode;
    logic signed [DATA_W-1:0] i_element_value;
    logic                     i_last_load;
    logic                     o_result_valid;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_final_element;
    logic                     o_no_data;
    logic                     o_overflowed;

    merge_sort_engine #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_element_value (i_element_value),
        .i_last_load     (i_last_load),
        .o_result_valid  (o_result_valid),
        .o_sorted_value  (o_sorted_value),
        .o_final_element (o_final_element),
        .o_no_data       (o_no_data),
        .o_overflowed    (o_overflowed)
    );

    // ------------------------------------------------------------------
    // Predictor state: the set as loaded, the same set in sorted order,
    // and the bookkeeping that decides what each fetch returns.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] loaded_words [DEPTH];
    logic signed [DATA_W-1:0] ordered_words [DEPTH];
    int                       set_count;
    int                       read_index;
    logic                     set_overflow;
    logic                     set_closed;

    // Fetch results that are owed by the engine, oldest first.
    t_sorted_word             expected_words [$];

    int                       mismatch_count;
    int                       quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sorts the loaded set into ascending order. Equal keys cannot be told apart on the
    // output, so a plain insertion sort gives the same sequence as a stable merge sort.
    task automatic order_set();
        logic signed [DATA_W-1:0] key;
        int                       j;
        for (int i = 0; i < set_count; i++) begin
            key = loaded_words[i];
            j = i - 1;
            while (j >= 0 && ordered_words[j] > key) begin
                ordered_words[j + 1] = ordered_words[j];
                j--;
            end
            ordered_words[j + 1] = key;
        end
        set_closed = 1'b1;
    endtask

    // Advances the predictor by one accepted word and queues the result a fetch owes.
    task automatic track_sorter(input logic op, input logic signed [DATA_W-1:0] value,
                                input logic last);
        t_sorted_word owed;
        if (op == OP_LOAD) begin
            // The first load after a sort opens a new set and forgets the old one.
            if (set_closed) begin
                set_count    = 0;
                read_index   = 0;
                set_overflow = 1'b0;
                set_closed   = 1'b0;
            end
            if (set_count < DEPTH) begin
                loaded_words[set_count] = value;
                set_count++;
            end else begin
                set_overflow = 1'b1;
            end
            if (last)
                order_set();
        end else begin
            owed.value      = '0;
            owed.final_flag = 1'b0;
            owed.empty      = 1'b1;
            owed.ovf        = set_overflow;
            if (set_closed && read_index < set_count) begin
                owed.value      = ordered_words[read_index];
                owed.final_flag = (read_index + 1 == set_count);
                owed.empty      = 1'b0;
                read_index++;
            end
            expected_words.push_back(owed);
        end
    endtask

    // Idle time after a word: mostly none, sometimes a few cycles, now and then a long pause.
    // In a burst the sender never idles.
    function automatic int pick_gap(input bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Draws a key: fully random, from a narrow band so that duplicates are common,
    // or from the edges of the signed range.
    function automatic logic signed [DATA_W-1:0] pick_key(input int flavour);
        case (flavour)
            0: return $urandom;
            1: return $signed($urandom_range(0, 16)) - 8;
            default: begin
                case ($urandom_range(0, 4))
                    0: return {1'b0, {(DATA_W-1){1'b1}}};
                    1: return {1'b1, {(DATA_W-1){1'b0}}};
                    2: return '0;
                    3: return '1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Presents one word and holds it until the engine takes it, then idles for gap cycles.
    // Must be entered just after a rising edge; start is only raised here and lowered by the
    // gap, so it never receives two assignments in the same step.
    task automatic send_word(input logic op, input logic signed [DATA_W-1:0] value,
                             input logic last, input int gap);
        start           <= 1'b1;
        i_opcode        <= op;
        i_element_value <= value;
        i_last_load     <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        track_sorter(op, value, last);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_word(input logic signed [DATA_W-1:0] value, input logic last,
                             input int gap);
        send_word(OP_LOAD, value, last, gap);
    endtask

    // A fetch carries random junk in the fields it is meant to ignore.
    task automatic fetch_word(input int gap);
        send_word(OP_FETCH, $urandom, 1'($urandom_range(0, 1)), gap);
    endtask

    // Stops sending until every owed result has come back. At least one edge passes, so
    // the next word is never raised in the step that lowers start.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker. Outputs are sampled at the rising edge that ends the
    // strobe cycle, so the values seen are those of the cycle just ended.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sorted_word owed;
        if (i_rst_n && o_result_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got value %0d",
                         $time, o_sorted_value);
                mismatch_count++;
            end else begin
                owed = expected_words.pop_front();
                if (o_sorted_value !== owed.value) begin
                    $display("%0t: sorted_value expected %0d, got %0d",
                             $time, owed.value, o_sorted_value);
                    mismatch_count++;
                end
                if (o_final_element !== owed.final_flag) begin
                    $display("%0t: final_element expected %0b, got %0b",
                             $time, owed.final_flag, o_final_element);
                    mismatch_count++;
                end
                if (o_no_data !== owed.empty) begin
                    $display("%0t: no_data expected %0b, got %0b",
                             $time, owed.empty, o_no_data);
                    mismatch_count++;
                end
                if (o_overflowed !== owed.ovf) begin
                    $display("%0t: overflowed expected %0b, got %0b",
                             $time, owed.ovf, o_overflowed);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: any accepted word, in either direction, counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset no set exists, so a fetch must report no data.
    task automatic test_fetch_after_reset();
        fetch_word(0);
        fetch_word(2);
    endtask

    // A small set holding both ends of the signed range, zero, minus one and duplicates;
    // it is read out fully and then twice more past its end.
    task automatic test_extreme_keys();
        load_word({1'b0, {(DATA_W-1){1'b1}}}, 1'b0, 0);
        load_word(32'sd5, 1'b0, 1);
        load_word({1'b1, {(DATA_W-1){1'b0}}}, 1'b0, 0);
        load_word('0, 1'b0, 0);
        load_word('1, 1'b0, 3);
        load_word(32'sd5, 1'b0, 0);
        load_word(32'sd1, 1'b0, 0);
        load_word({1'b1, {(DATA_W-1){1'b0}}}, 1'b1, 0);
        repeat (10) fetch_word(pick_gap(1'b0));
    endtask

    // A fetch while the set is still open gives no data and does not disturb the set.
    // The set is then closed and only partly read before a new load replaces it.
    task automatic test_open_set_and_replace();
        load_word(-32'sd3, 1'b0, 0);
        fetch_word(0);
        load_word(32'sd7, 1'b0, 0);
        load_word(-32'sd9, 1'b1, 0);
        fetch_word(0);
        load_word(32'sd42, 1'b1, 1);
        fetch_word(0);
        fetch_word(0);
    endtask

    // A full set followed by two loads that must be dropped, the second one closing
    // the set; the sort still runs and every fetch reports the overflow. The smallest
    // part of the sorted set is read back before a fresh set replaces it.
    task automatic test_full_set();
        for (int i = 0; i < DEPTH; i++)
            load_word(pick_key(i % 3), 1'b0, 0);
        load_word($urandom, 1'b0, 0);
        load_word($urandom, 1'b1, 0);
        for (int i = 0; i < FULL_READS; i++)
            fetch_word((i % 97 == 0) ? pick_gap(1'b0) : 0);
        // The sender holds back once until every result has arrived.
        wait_for_drain();
        // A fresh set must no longer report the overflow.
        load_word(32'sd1, 1'b1, 0);
        fetch_word(0);
    endtask

    // Random sets: mostly well-formed load-then-fetch sequences with random keys and
    // sizes, some read only in part, with stray fetches mixed into open sets.
    task automatic test_random_sets();
        int  sent;
        int  set_size;
        int  flavour;
        int  reads;
        bit  burst;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst    = ($urandom_range(0, 3) == 0);
            flavour  = $urandom_range(0, 2);
            set_size = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
            for (int i = 0; i < set_size; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    fetch_word(pick_gap(burst));
                    sent++;
                end
                load_word(pick_key(flavour), (i == set_size - 1), pick_gap(burst));
                sent++;
            end
            reads = ($urandom_range(0, 3) != 0) ? set_size + $urandom_range(0, 2)
                                                : $urandom_range(0, set_size);
            for (int i = 0; i < reads; i++) begin
                fetch_word(pick_gap(burst));
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_drain();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_opcode        <= OP_LOAD;
        i_element_value <= '0;
        i_last_load     <= 1'b0;
        set_count       = 0;
        read_index      = 0;
        set_overflow    = 1'b0;
        set_closed      = 1'b0;
        mismatch_count  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fetch_after_reset();
        test_extreme_keys();
        test_open_set_and_replace();
        test_full_set();
        test_random_sets();

        // Let the last results arrive, then allow a few more cycles for anything stray.
        wait_for_drain();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: merge_sort_engine.f
+incdir+hw/rtl
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mse_ctrl.sv
hw/rtl/mse_dp.sv
hw/rtl/merge_sort_engine.sv
dv/tb_top.sv
